// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the range LCM unit.
// Needs nothing else; the files that assert take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, disabled during reset.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must never hold while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_SYNC(label, clk, rst_n, !(cond), msg)

`endif

// File: rtl/rlcm_pkg.sv
// Shared widths and divider request/response types of the range LCM unit.
// No dependencies; used by rlcm_div and range_lcm_by_prime_powers_unit.
package rlcm_pkg;

    localparam int VAL_W  = 6;   // width of the bound and of any value being factored
    localparam int DIV_W  = 4;   // trial divisor width; d*d exceeds any 6-bit value at d = 8
    localparam int EXP_W  = 3;   // exponent width, wraps like the exponent counter
    localparam int LCM_W  = 64;  // result width
    localparam int DCNT_W = 3;   // divider step counter, counts VAL_W steps

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [VAL_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

// File: rtl/rlcm_div.sv
// Shared restoring divider of the range LCM unit, one quotient bit per cycle.
// Depends on rlcm_pkg for widths and the request/response structs.
module rlcm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rlcm_pkg::t_div_req i_req,
    output rlcm_pkg::t_div_rsp o_rsp
);
    import rlcm_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [VAL_W-1:0]  r_quo, n_quo;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W:0]    w_shift;
    logic [DIV_W:0]    w_diff;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        w_shift = {r_rem, r_quo[VAL_W-1]};
        w_diff  = w_shift - {1'b0, i_req.divisor};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_req.dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            // Partial remainder stays below the divisor, so it fits in DIV_W bits.
            if (w_shift >= {1'b0, i_req.divisor}) begin
                n_rem = w_diff[DIV_W-1:0];
                n_quo = {r_quo[VAL_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DIV_W-1:0];
                n_quo = {r_quo[VAL_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(VAL_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// File: rtl/range_lcm_by_prime_powers_unit.sv
// Top level of the range LCM unit: least common multiple of 1..n; uses rlcm_pkg, rlcm_div.
// For n below 2 only the product sweep runs; for larger n the trial divisions on the shared
// 6-step divider dominate the run time.
// One item at a time; the next item is accepted once the current result sits in the output
// register, so a new item is never taken before the last one is through.
// Synchronous active-low reset clears the sequencer, the exponent valid bits and output valid.
`include "assert_macros.svh"

module range_lcm_by_prime_powers_unit #(
    parameter int MAX_N = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rlcm_pkg::VAL_W-1:0]  i_upper,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rlcm_pkg::LCM_W-1:0]  o_lcm,
    output logic                        o_overflow
);
    import rlcm_pkg::*;

    // Exponent store is indexed by prime; the product sweep counter must reach MAX_N + 1.
    localparam int IDX_W   = $clog2(MAX_N + 1);
    localparam int PCNT_W  = $clog2(MAX_N + 2);
    localparam int PROD_W  = LCM_W + IDX_W;
    localparam int VAL_MAX = (1 << VAL_W) - 1;
    localparam int N_CAP   = (MAX_N < VAL_MAX) ? MAX_N : VAL_MAX;
    localparam int FIRST_FACTOR = 2;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_V_START = 9'b000000010,
        S_D_CHECK = 9'b000000100,
        S_DIV     = 9'b000001000,
        S_D_UPD   = 9'b000010000,
        S_R_UPD   = 9'b000100000,
        S_P_START = 9'b001000000,
        S_P_LOAD  = 9'b010000000,
        S_P_MUL   = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [VAL_W-1:0]   r_n, n_n;        // clamped bound
    logic [VAL_W:0]     r_v, n_v;        // integer being factored
    logic [VAL_W-1:0]   r_rem, n_rem;    // what is left of it
    logic [DIV_W-1:0]   r_d, n_d;        // trial divisor
    logic [EXP_W-1:0]   r_e, n_e;        // exponent of r_d found so far
    logic [PCNT_W-1:0]  r_p, n_p;        // prime index in the product sweep
    logic [EXP_W-1:0]   r_k, n_k;        // multiplications left for r_p
    logic [LCM_W-1:0]   r_acc, n_acc;
    logic               r_ovf, n_ovf;
    logic               r_out_valid;
    logic [LCM_W-1:0]   r_lcm;
    logic               r_out_ovf;

    // Exponent store: a memory with registered read, plus a valid bit per entry so that
    // clearing at the start of an item resets only the valid bits, all at once.
    logic [EXP_W-1:0]   r_exp_mem [0:MAX_N];
    logic [MAX_N:0]     r_exp_vld;
    logic [EXP_W-1:0]   r_rd_data;
    logic               r_rd_vld;

    logic               w_accept;
    logic               w_clr;
    logic               w_load;
    logic               w_we;
    logic [IDX_W-1:0]   w_wa;
    logic [EXP_W-1:0]   w_wd;
    logic [IDX_W-1:0]   w_ra;
    logic [EXP_W-1:0]   w_cur;
    logic [2*DIV_W-1:0] w_dsq;
    logic [PROD_W-1:0]  w_prod;
    logic               w_mul_ovf;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    rlcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // An entry never written in this item reads as exponent zero.
    assign w_cur = r_rd_vld ? r_rd_data : '0;

    // Loop test of the trial division: d*d against what remains.
    assign w_dsq = (2*DIV_W)'(r_d) * (2*DIV_W)'(r_d);

    // One 64 x IDX_W multiply per cycle; any bit above 64 means the product saturates.
    assign w_prod    = PROD_W'(r_acc) * PROD_W'(r_p[IDX_W-1:0]);
    assign w_mul_ovf = |w_prod[PROD_W-1:LCM_W];

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_v     = r_v;
        n_rem   = r_rem;
        n_d     = r_d;
        n_e     = r_e;
        n_p     = r_p;
        n_k     = r_k;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        w_clr   = 1'b0;
        w_load  = 1'b0;
        w_we    = 1'b0;
        w_wa    = '0;
        w_wd    = '0;
        w_ra    = '0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_rem;
        w_div_req.divisor  = r_d;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // A bound above MAX_N is taken as MAX_N.
                    if (int'(i_upper) > N_CAP) begin
                        n_n = VAL_W'(N_CAP);
                    end else begin
                        n_n = i_upper;
                    end
                    n_v     = (VAL_W+1)'(FIRST_FACTOR);
                    n_acc   = LCM_W'(1);
                    n_ovf   = 1'b0;
                    w_clr   = 1'b1;
                    n_state = S_V_START;
                end
            end
            S_V_START: begin
                // All integers 2..n factored: move on to the product sweep.
                if (r_v > {1'b0, r_n}) begin
                    n_p     = PCNT_W'(FIRST_FACTOR);
                    n_state = S_P_START;
                end else begin
                    n_rem   = r_v[VAL_W-1:0];
                    n_d     = DIV_W'(FIRST_FACTOR);
                    n_e     = '0;
                    n_state = S_D_CHECK;
                end
            end
            S_D_CHECK: begin
                if (w_dsq <= (2*DIV_W)'(r_rem)) begin
                    w_div_req.start = 1'b1;
                    n_state         = S_DIV;
                end else if (r_rem > VAL_W'(1) && int'(r_rem) <= MAX_N) begin
                    // What is left above 1 is a prime with exponent one.
                    w_ra    = IDX_W'(r_rem);
                    n_state = S_R_UPD;
                end else begin
                    n_v     = r_v + 1'b1;
                    n_state = S_V_START;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.rem == '0) begin
                        // Divides evenly: keep the quotient and try the same divisor again.
                        n_rem              = w_div_rsp.quot;
                        n_e                = r_e + 1'b1;
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = w_div_rsp.quot;
                    end else begin
                        w_ra    = IDX_W'(r_d);
                        n_state = S_D_UPD;
                    end
                end
            end
            S_D_UPD: begin
                if (r_e > w_cur) begin
                    w_we = 1'b1;
                    w_wa = IDX_W'(r_d);
                    w_wd = r_e;
                end
                n_d     = r_d + 1'b1;
                n_e     = '0;
                n_state = S_D_CHECK;
            end
            S_R_UPD: begin
                if (w_cur == '0) begin
                    w_we = 1'b1;
                    w_wa = IDX_W'(r_rem);
                    w_wd = EXP_W'(1);
                end
                n_v     = r_v + 1'b1;
                n_state = S_V_START;
            end
            S_P_START: begin
                if (r_p > PCNT_W'(MAX_N)) begin
                    // Finished; wait only if the previous result is still unclaimed.
                    if (!r_out_valid || i_out_ready) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    w_ra    = r_p[IDX_W-1:0];
                    n_state = S_P_LOAD;
                end
            end
            S_P_LOAD: begin
                n_k     = w_cur;
                n_state = S_P_MUL;
            end
            S_P_MUL: begin
                if (r_k == '0) begin
                    n_p     = r_p + 1'b1;
                    n_state = S_P_START;
                end else begin
                    // Once saturated, the remaining multiplications change nothing.
                    if (!r_ovf) begin
                        if (w_mul_ovf) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = w_prod[LCM_W-1:0];
                        end
                    end
                    n_k = r_k - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_exp_vld   <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_clr) begin
                r_exp_vld <= '0;
            end else if (w_we) begin
                r_exp_vld[w_wa] <= 1'b1;
            end
        end
    end

    // Working registers and result.
    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_v   <= n_v;
        r_rem <= n_rem;
        r_d   <= n_d;
        r_e   <= n_e;
        r_p   <= n_p;
        r_k   <= n_k;
        r_acc <= n_acc;
        r_ovf <= n_ovf;
        if (w_load) begin
            r_lcm     <= r_ovf ? '1 : r_acc;
            r_out_ovf <= r_ovf;
        end
    end

    // Exponent store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_exp_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_exp_mem[w_ra];
        r_rd_vld  <= r_exp_vld[w_ra];
    end

    assign o_out_valid = r_out_valid;
    assign o_lcm       = r_lcm;
    assign o_overflow  = r_out_ovf;

    // The shared divider is never left running while a new item may be taken.
    `ASSERT_SYNC(a_div_idle_when_ready, i_clk, i_rst_n,
                 o_in_ready |-> !w_div_rsp.busy, "divider busy while idle")
    // A division result only arrives while the sequencer waits for it.
    `ASSERT_SYNC(a_div_done_in_div, i_clk, i_rst_n,
                 w_div_rsp.done |-> (r_state == S_DIV), "divider done outside wait state")
    // A saturated result always carries all ones.
    `ASSERT_SYNC(a_sat_all_ones, i_clk, i_rst_n,
                 (o_out_valid && o_overflow) |-> (o_lcm == '1), "saturated result not all ones")
    // Saturation is sticky within an item.
    `ASSERT_SYNC(a_ovf_sticky, i_clk, i_rst_n,
                 (r_ovf && !w_accept) |=> r_ovf, "overflow flag dropped within an item")

endmodule

// File: verif/range_lcm_by_prime_powers_unit_tb.sv
// Testbench for range_lcm_by_prime_powers_unit: the LCM of 1..n for 6-bit bounds n.
// Uses types and widths from rlcm_pkg. A directed table comes first, then random bounds.
// Results are checked against the table or a local predictor, in several idle/stall mixes.
`timescale 1ns / 1ps

module range_lcm_by_prime_powers_unit_tb;

    import rlcm_pkg::*;

    // Largest bound the unit factors. This matches the default MAX_N of the unit.
    localparam int BOUND_MAX = 63;
    localparam logic [LCM_W-1:0] ALL_ONES = {LCM_W{1'b1}};

    // Random bounds per idling phase. The directed table adds about two dozen more items.
    localparam int RANDOM_PER_PHASE = 140;
    localparam int PHASE_COUNT = 4;

    // Percent chance per cycle that the sender idles or the receiver stalls, by phase:
    // no idling, a mostly idle sender, a mostly stalling receiver, and both at once.
    localparam int unsigned SENDER_IDLE[PHASE_COUNT] = '{0, 70, 0, 30};
    localparam int unsigned RECV_STALL[PHASE_COUNT]  = '{0, 0, 70, 30};

    // After the last result we keep the clock running for a drain period, so that a stray
    // extra result would still be seen.
    localparam int DRAIN_CYCLES = 2600;

    // Slowest correct run: about 580 items of the largest bound, plus stalls, at 2 ns per
    // cycle. That is roughly 3 ms, so this limit leaves a wide margin.
    localparam int LIMIT_NS = 20_000_000;

    typedef struct packed {
        logic [LCM_W-1:0] lcm;
        logic             overflow;
    } t_lcm_result;

    // One row of the directed table. When has_typed is set, the expected result is given
    // in the row. Otherwise it comes from the predictor.
    typedef struct packed {
        logic [VAL_W-1:0] bound;
        logic             has_typed;
        t_lcm_result      typed;
    } t_directed_row;

    localparam int DIRECTED_COUNT = 24;

    // The rows cover both small bounds, whose result is 1, and the powers of two and their
    // neighbors. They also cover the range near the overflow edge: lcm(1..46) still fits in
    // 64 bits, while the factor 47 makes it saturate. Next come the largest bounds. Last
    // comes a small bound after the largest one, which shows that the exponents are cleared
    // again for each item.
    localparam t_directed_row DIRECTED_ROWS[DIRECTED_COUNT] = '{
        '{6'd0,  1'b1, '{64'd1, 1'b0}},
        '{6'd1,  1'b1, '{64'd1, 1'b0}},
        '{6'd2,  1'b1, '{64'd2, 1'b0}},
        '{6'd3,  1'b0, '{64'd0, 1'b0}},
        '{6'd4,  1'b0, '{64'd0, 1'b0}},
        '{6'd5,  1'b0, '{64'd0, 1'b0}},
        '{6'd6,  1'b0, '{64'd0, 1'b0}},
        '{6'd7,  1'b0, '{64'd0, 1'b0}},
        '{6'd8,  1'b0, '{64'd0, 1'b0}},
        '{6'd9,  1'b0, '{64'd0, 1'b0}},
        '{6'd15, 1'b0, '{64'd0, 1'b0}},
        '{6'd16, 1'b0, '{64'd0, 1'b0}},
        '{6'd31, 1'b0, '{64'd0, 1'b0}},
        '{6'd32, 1'b0, '{64'd0, 1'b0}},
        '{6'd40, 1'b0, '{64'd0, 1'b0}},
        '{6'd41, 1'b0, '{64'd0, 1'b0}},
        '{6'd43, 1'b0, '{64'd0, 1'b0}},
        '{6'd46, 1'b0, '{64'd0, 1'b0}},
        '{6'd47, 1'b1, '{ALL_ONES, 1'b1}},
        '{6'd48, 1'b1, '{ALL_ONES, 1'b1}},
        '{6'd62, 1'b1, '{ALL_ONES, 1'b1}},
        '{6'd63, 1'b1, '{ALL_ONES, 1'b1}},
        '{6'd0,  1'b1, '{64'd1, 1'b0}},
        '{6'd5,  1'b0, '{64'd0, 1'b0}}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [VAL_W-1:0] i_upper;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [LCM_W-1:0] o_lcm;
    logic             o_overflow;

    // Results still owed by the unit, oldest first.
    t_lcm_result pending_lcm[$];
    int          mismatch_count = 0;

    // Idle and stall mix of the current phase. The sender and receiver loops read these.
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;

    range_lcm_by_prime_powers_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_upper     (i_upper),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_lcm       (o_lcm),
        .o_overflow  (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // Predicts the LCM of 1..bound. Each integer is factored by trial division, and the
    // highest exponent seen for each prime is kept in a 3-bit field that wraps, as in the
    // unit. The prime powers are then multiplied together in ascending order of the prime.
    // The first multiplication that would pass 64 bits saturates the result.
    function automatic t_lcm_result lcm_of_range(input logic [VAL_W-1:0] bound);
        logic [EXP_W-1:0] top_exp[BOUND_MAX+1];
        logic [EXP_W-1:0] e;
        logic [LCM_W-1:0] acc;
        logic             ovf;
        int unsigned      n;
        int unsigned      v;
        int unsigned      rem;
        int unsigned      d;
        int unsigned      p;
        int unsigned      k;
        t_lcm_result      res;
        n = (bound > BOUND_MAX) ? BOUND_MAX : bound;
        foreach (top_exp[i]) top_exp[i] = '0;
        for (v = 2; v <= n; v++) begin
            rem = v;
            for (d = 2; d * d <= rem; d++) begin
                e = '0;
                while (rem % d == 0) begin
                    rem = rem / d;
                    e = e + 1'b1;
                end
                if (e > top_exp[d]) begin
                    top_exp[d] = e;
                end
            end
            // Whatever is left above 1 is a prime that appears once.
            if (rem > 1 && rem <= BOUND_MAX && top_exp[rem] < 1) begin
                top_exp[rem] = EXP_W'(1);
            end
        end
        acc = LCM_W'(1);
        ovf = 1'b0;
        for (p = 2; p <= BOUND_MAX; p++) begin
            for (k = 0; k < top_exp[p]; k++) begin
                if (!ovf) begin
                    if (acc > ALL_ONES / p) begin
                        ovf = 1'b1;
                    end else begin
                        acc = acc * p;
                    end
                end
            end
        end
        res.overflow = ovf;
        res.lcm      = ovf ? ALL_ONES : acc;
        return res;
    endfunction

    // Offers one bound, after an idle gap drawn from the current phase, and holds it until
    // it is accepted. This is called right after a rising edge. If there is no gap, valid
    // simply stays high from the previous item, so it gets one assignment in that step.
    task automatic send_bound(input logic [VAL_W-1:0] bound, input logic has_typed,
                              input t_lcm_result typed);
        t_lcm_result want;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_upper    <= bound;
        do @(posedge i_clk); while (!o_in_ready);
        want = has_typed ? typed : lcm_of_range(bound);
        pending_lcm = {pending_lcm, want};
    endtask

    // Receiver. The handshake is sampled right after the edge, where all signals still hold
    // the values that the edge saw. Ready for the next edge is then drawn from the stall mix.
    initial begin
        t_lcm_result want;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_lcm.size() == 0) begin
                    $error("result with no item waiting: lcm %h overflow %b",
                           o_lcm, o_overflow);
                    mismatch_count++;
                end else begin
                    want = pending_lcm.pop_front();
                    if (o_lcm !== want.lcm) begin
                        $error("lcm: expected %h, got %h", want.lcm, o_lcm);
                        mismatch_count++;
                    end
                    if (o_overflow !== want.overflow) begin
                        $error("overflow: expected %b, got %b", want.overflow, o_overflow);
                        mismatch_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus. The random bounds are mostly small, because a large bound is slow. About a
    // quarter of them span the full 6-bit range, which reaches the overflow region and sets
    // every bit of the bound both ways.
    initial begin
        logic [VAL_W-1:0] bound;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_upper    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            send_bound(DIRECTED_ROWS[r].bound, DIRECTED_ROWS[r].has_typed,
                       DIRECTED_ROWS[r].typed);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            sender_idle_pct = SENDER_IDLE[ph];
            recv_stall_pct  = RECV_STALL[ph];
            repeat (RANDOM_PER_PHASE) begin
                bound = VAL_W'(($urandom_range(99) < 75) ? $urandom_range(15)
                                                         : $urandom_range(63));
                send_bound(bound, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        while (pending_lcm.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
